>>> rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_CHAR_LIMIT      = 2'd0;
	localparam logic [1:0] CFG_BYTE_LIMIT      = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_CAPACITY = 2'd2;
	localparam logic [1:0] CFG_COUNT_ONLY      = 2'd3;

	// Completion status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NUL        = 3'd1;
	localparam logic [2:0] ST_STRAY_CONT = 3'd2;
	localparam logic [2:0] ST_OVERLONG   = 3'd3;
	localparam logic [2:0] ST_LEAD_RANGE = 3'd4;
	localparam logic [2:0] ST_BYTE_BUDGET = 3'd5;
	localparam logic [2:0] ST_OUT_FULL   = 3'd6;
	localparam logic [2:0] ST_BAD_CONT   = 3'd7;

	localparam logic [7:0] CONT_LO      = 8'h80;
	localparam logic [7:0] CONT_HI      = 8'hBF;
	localparam logic [7:0] LEAD2_LO     = 8'hC2;
	localparam logic [7:0] LEAD3_LO     = 8'hE0;
	localparam logic [7:0] LEAD4_LO     = 8'hF0;
	localparam logic [7:0] LEAD_BAD_LO  = 8'hF5;
	localparam logic [7:0] CONT_MASK    = 8'h3F;
	localparam logic [7:0] LEAD2_MASK   = 8'h1F;
	localparam logic [7:0] LEAD3_MASK   = 8'h0F;
	localparam logic [7:0] LEAD4_MASK   = 8'h07;

	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [20:0] SUPP_OFFSET  = 21'h10000;

	typedef struct packed {
		logic [15:0] char_limit;
		logic [15:0] byte_limit;
		logic [15:0] output_capacity;
		logic        count_only;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [15:0] unit;
		logic        unit_valid;
		logic        finished;
		logic [2:0]  status;
		logic [15:0] bytes_consumed;
		logic [15:0] units_written;
	} result_t;

endpackage

>>> rtl/utd_skid.sv
// Two-entry input skid buffer with registered ready.
`timescale 1ns / 1ps

module utd_skid import utd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     up_valid,
	output logic     up_ready,
	input  in_item_t up_item,
	output logic     dn_valid,
	input  logic     dn_ready,
	output in_item_t dn_item
);

	logic     main_valid_q, skid_valid_q;
	in_item_t main_q, skid_q;
	logic     up_take, dn_take;

	assign up_ready = !skid_valid_q;
	assign dn_valid = main_valid_q;
	assign dn_item  = main_q;
	assign up_take  = up_valid && up_ready;
	assign dn_take  = main_valid_q && dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (up_take) begin
				// park the transfer when the main slot is still held
				if (main_valid_q && !dn_take)
					skid_valid_q <= 1'b1;
				else
					main_valid_q <= 1'b1;
			end else if (dn_take) begin
				if (skid_valid_q)
					skid_valid_q <= 1'b0;
				else
					main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_take) begin
			if (main_valid_q && !dn_take)
				skid_q <= up_item;
			else
				main_q <= up_item;
		end else if (dn_take && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

endmodule

>>> rtl/utd_core.sv
// Decode step and result register: one byte per cycle while the result register is free, up to three results per byte.
`timescale 1ns / 1ps

module utd_core import utd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     res_valid,
	input  logic     res_ready,
	output result_t  res,
	output logic     res_last
);

	// decoder state
	logic [1:0]             pend_q;
	logic [20:0]            acc_q;
	logic [15:0]            chars_q;
	logic [17:0]            bytes_q;
	logic [15:0]            space_q;
	logic [COUNT_WIDTH-1:0] cons_q;
	logic [COUNT_WIDTH-1:0] wr_q;
	logic                   done_q;
	logic [2:0]             seq_q;

	logic [1:0]             nx_pend;
	logic [20:0]            nx_acc;
	logic [15:0]            nx_chars;
	logic [17:0]            nx_bytes;
	logic [15:0]            nx_space;
	logic [COUNT_WIDTH-1:0] nx_cons;
	logic [COUNT_WIDTH-1:0] nx_wr;
	logic                   nx_done;
	logic [2:0]             nx_seq;

	result_t                res_nx [3];
	logic [1:0]             n_res;

	// result register, slot 0 drives the port
	result_t                slot_q [3];
	logic [1:0]             cnt_q;

	logic                   accept, take;

	function automatic result_t mk_result(input logic [15:0] u, input logic uv,
			input logic fin, input logic [2:0] st, input logic [COUNT_WIDTH-1:0] c,
			input logic [COUNT_WIDTH-1:0] w);
		result_t r;
		r.unit           = u;
		r.unit_valid     = uv;
		r.finished       = fin;
		r.status         = st;
		r.bytes_consumed = 16'(c);
		r.units_written  = 16'(w);
		return r;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic        do_complete, do_finish;
		logic [2:0]  len;
		logic [1:0]  need;
		logic [20:0] lead_acc;
		logic [19:0] v;
		logic [1:0]  cost;

		b           = item.data_byte;
		do_complete = 1'b0;
		do_finish   = 1'b0;
		len         = 3'd1;
		need        = 2'd1;
		lead_acc    = '0;
		v           = '0;
		cost        = 2'd1;
		n_res       = 2'd0;
		for (int i = 0; i < 3; i++)
			res_nx[i] = '0;

		nx_pend  = pend_q;
		nx_acc   = acc_q;
		nx_chars = chars_q;
		nx_bytes = bytes_q;
		nx_space = space_q;
		nx_cons  = cons_q;
		nx_wr    = wr_q;
		nx_done  = done_q;
		nx_seq   = seq_q;

		if (item.first) begin
			nx_chars = cfg.char_limit;
			nx_bytes = (cfg.byte_limit != 16'd0) ? {2'b00, cfg.byte_limit}
				: ({2'b00, cfg.char_limit} + {1'b0, cfg.char_limit, 1'b0});
			nx_space = cfg.output_capacity;
			nx_cons  = '0;
			nx_wr    = '0;
			nx_pend  = 2'd0;
			nx_acc   = '0;
			nx_seq   = 3'd0;
			nx_done  = 1'b0;
		end

		if (item.first || !done_q) begin
			if (nx_pend != 2'd0) begin
				if (b < CONT_LO || b > CONT_HI) begin
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_BAD_CONT, nx_cons, nx_wr);
					n_res   = n_res + 2'd1;
					nx_done = 1'b1;
					nx_pend = 2'd0;
				end else begin
					nx_acc  = {nx_acc[14:0], b[5:0] & CONT_MASK[5:0]};
					nx_cons = nx_cons + 1'b1;
					nx_pend = nx_pend - 2'd1;
					do_complete = (nx_pend == 2'd0);
				end
			end else if (nx_chars == 16'd0 || nx_bytes == 18'd0) begin
				do_finish = 1'b1;
			end else if (b == 8'd0 || (b >= CONT_LO && b <= CONT_HI) || b < LEAD2_LO
					&& b > CONT_HI || b >= LEAD_BAD_LO) begin
				priority if (b == 8'd0)
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_NUL, nx_cons, nx_wr);
				else if (b <= CONT_HI && b >= CONT_LO)
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_STRAY_CONT, nx_cons,
						nx_wr);
				else if (b < LEAD2_LO)
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_OVERLONG, nx_cons, nx_wr);
				else
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_LEAD_RANGE, nx_cons,
						nx_wr);
				n_res   = n_res + 2'd1;
				nx_done = 1'b1;
				nx_pend = 2'd0;
			end else begin
				priority if (b < CONT_LO) begin
					len = 3'd1; need = 2'd1; lead_acc = {13'd0, b};
				end else if (b < LEAD3_LO) begin
					len = 3'd2; need = 2'd1; lead_acc = {13'd0, b & LEAD2_MASK};
				end else if (b < LEAD4_LO) begin
					len = 3'd3; need = 2'd1; lead_acc = {13'd0, b & LEAD3_MASK};
				end else begin
					len = 3'd4; need = 2'd2; lead_acc = {13'd0, b & LEAD4_MASK};
				end
				nx_acc = lead_acc;
				if (nx_bytes < {15'd0, len}) begin
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_BYTE_BUDGET, nx_cons,
						nx_wr);
					n_res   = n_res + 2'd1;
					nx_done = 1'b1;
					nx_pend = 2'd0;
				end else if (!cfg.count_only && nx_space < {14'd0, need}) begin
					res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_OUT_FULL, nx_cons, nx_wr);
					n_res   = n_res + 2'd1;
					nx_done = 1'b1;
					nx_pend = 2'd0;
				end else begin
					nx_seq  = len;
					nx_cons = nx_cons + 1'b1;
					nx_pend = 2'(len - 3'd1);
					do_complete = (len == 3'd1);
				end
			end
		end

		if (do_complete) begin
			if (!cfg.count_only) begin
				if (nx_seq == 3'd4) begin
					v = 20'(nx_acc - SUPP_OFFSET);
					nx_wr = nx_wr + 1'b1;
					if (nx_space != 16'd0)
						nx_space = nx_space - 16'd1;
					res_nx[n_res] = mk_result(HI_SURR_BASE + {6'd0, v[19:10]}, 1'b1, 1'b0,
						ST_OK, nx_cons, nx_wr);
					n_res = n_res + 2'd1;
					nx_wr = nx_wr + 1'b1;
					if (nx_space != 16'd0)
						nx_space = nx_space - 16'd1;
					res_nx[n_res] = mk_result(LO_SURR_BASE + {6'd0, v[9:0]}, 1'b1, 1'b0,
						ST_OK, nx_cons, nx_wr);
					n_res = n_res + 2'd1;
				end else begin
					nx_wr = nx_wr + 1'b1;
					if (nx_space != 16'd0)
						nx_space = nx_space - 16'd1;
					res_nx[n_res] = mk_result(nx_acc[15:0], 1'b1, 1'b0, ST_OK, nx_cons,
						nx_wr);
					n_res = n_res + 2'd1;
				end
			end
			cost     = (nx_seq == 3'd4) ? 2'd2 : 2'd1;
			nx_chars = (nx_chars >= {14'd0, cost}) ? nx_chars - {14'd0, cost} : 16'd0;
			nx_bytes = (nx_bytes >= {15'd0, nx_seq}) ? nx_bytes - {15'd0, nx_seq} : 18'd0;
			nx_pend  = 2'd0;
			do_finish = (nx_chars == 16'd0 || nx_bytes == 18'd0);
		end

		if (do_finish) begin
			nx_done = 1'b1;
			if (cfg.count_only)
				res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_OK, nx_cons, nx_wr);
			else if (nx_space == 16'd0) begin
				res_nx[n_res] = mk_result(16'd0, 1'b0, 1'b1, ST_OUT_FULL, nx_cons, nx_wr);
				nx_pend = 2'd0;
			end else
				res_nx[n_res] = mk_result(16'd0, 1'b1, 1'b1, ST_OK, nx_cons, nx_wr);
			n_res = n_res + 2'd1;
		end
	end

	assign res_valid  = (cnt_q != 2'd0);
	assign res_last   = (cnt_q == 2'd1);
	assign res        = slot_q[0];
	assign take       = res_valid && res_ready;
	// take a byte once the held batch is gone or leaves with this transfer
	assign item_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && res_ready);
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			acc_q   <= '0;
			chars_q <= '0;
			bytes_q <= '0;
			space_q <= '0;
			cons_q  <= '0;
			wr_q    <= '0;
			done_q  <= 1'b1;
			seq_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				pend_q  <= nx_pend;
				acc_q   <= nx_acc;
				chars_q <= nx_chars;
				bytes_q <= nx_bytes;
				space_q <= nx_space;
				cons_q  <= nx_cons;
				wr_q    <= nx_wr;
				done_q  <= nx_done;
				seq_q   <= nx_seq;
			end
			if (accept && n_res != 2'd0)
				cnt_q <= n_res;
			else if (take)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			slot_q <= res_nx;
		end else if (take) begin
			// advance the batch by one slot
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder top level: configuration registers, input skid, decode core.
// Path: a byte passes through the skid register and then the result register, which
// drives the first result of the byte onto the output.
// Throughput: one byte per cycle while each byte yields at most one result and the output
// is ready; a byte that yields k results holds the result register until all k are taken.
// Reset: configuration clears to zero, the decoder goes idle until a byte marked first.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder import utd_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] unit,
	output logic        unit_valid,
	output logic        finished,
	output logic [2:0]  status,
	output logic [15:0] bytes_consumed,
	output logic [15:0] units_written,
	output logic        last
);

	cfg_t     cfg_q;
	in_item_t up_item, core_item;
	logic     core_valid, core_ready;
	result_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHAR_LIMIT:      cfg_q.char_limit      <= cfg_data;
				CFG_BYTE_LIMIT:      cfg_q.byte_limit      <= cfg_data;
				CFG_OUTPUT_CAPACITY: cfg_q.output_capacity <= cfg_data;
				CFG_COUNT_ONLY:      cfg_q.count_only      <= cfg_data[0];
			endcase
		end
	end

	assign up_item.data_byte = data_byte;
	assign up_item.first     = first;

	utd_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.up_item  (up_item),
		.dn_valid (core_valid),
		.dn_ready (core_ready),
		.dn_item  (core_item)
	);

	utd_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (core_valid),
		.item_ready (core_ready),
		.item       (core_item),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res),
		.res_last   (last)
	);

	assign unit           = res.unit;
	assign unit_valid     = res.unit_valid;
	assign finished       = res.finished;
	assign status         = res.status;
	assign bytes_consumed = res.bytes_consumed;
	assign units_written  = res.units_written;

endmodule
